// ----- design/ldsd_pkg.sv -----
// Shared types and defaults for the local dead store detector.
// Holds the action codes, the queue word formats and the back-end state type.
// Has no dependencies; the front, the back and the top refer to it by scoped names.
package ldsd_pkg;

  // Default number of tracked locations in the associative table.
  localparam int TABLE_ENTRIES_DEF = 16;
  // Default depth of the queue between front and back, and of the result queue.
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int BASE_W = 32;
  localparam int OFFS_W = 32;
  localparam int TYPE_W = 8;
  localparam int TAG_W  = 16;
  localparam int CNT_W  = 16;

  typedef enum logic [1:0] {
    ACT_STORE    = 2'd0,
    ACT_VOLATILE = 2'd1,
    ACT_LOAD     = 2'd2,
    ACT_CLEAR    = 2'd3
  } act_e_t;

  // Classified event as it travels from the front to the back.
  typedef struct packed {
    logic                      is_store;
    logic                      is_erase;
    logic                      is_clear;
    logic [BASE_W-1:0]         base_id;
    logic signed [OFFS_W-1:0]  loc_offset;
    logic [TYPE_W-1:0]         type_id;
    logic [TAG_W-1:0]          store_tag;
  } op_t;

  // One result word.
  typedef struct packed {
    logic              dead_found;
    logic [TAG_W-1:0]  dead_tag;
    logic              table_full;
    logic [CNT_W-1:0]  dead_total;
  } res_t;

  typedef enum logic {
    BK_LOOKUP = 1'b0,
    BK_UPDATE = 1'b1
  } bk_state_t;

endpackage

// ----- design/ldsd_fifo.sv -----
// Small first-in first-out queue of generic width with show-ahead read.
// Used between the front and the back, and for finished result words.
// Depends on nothing but its parameters.
module ldsd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/ldsd_front.sv -----
// Front end: accepts input words and classifies the action into an event.
// Holds one register stage that feeds the queue toward the back end.
// Depends on ldsd_pkg for the action codes and the event format.
module ldsd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_base_id,
  input  logic signed [31:0] in_loc_offset,
  input  logic [7:0]         in_type_id,
  input  logic [15:0]        in_store_tag,
  output logic               q_push,
  output ldsd_pkg::op_t      q_data,
  input  logic               q_full
);

  logic          valid_r, valid_nxt;
  ldsd_pkg::op_t op_r;
  ldsd_pkg::op_t op_dec;
  logic          accept;

  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r;
  assign q_data  = op_r;

  always_comb begin
    op_dec             = '0;
    op_dec.base_id     = in_base_id;
    op_dec.loc_offset  = in_loc_offset;
    op_dec.type_id     = in_type_id;
    op_dec.store_tag   = in_store_tag;
    unique case (ldsd_pkg::act_e_t'(in_action))
      ldsd_pkg::ACT_STORE:    op_dec.is_store = 1'b1;
      ldsd_pkg::ACT_VOLATILE: op_dec.is_erase = 1'b1;
      ldsd_pkg::ACT_LOAD:     op_dec.is_erase = 1'b1;
      ldsd_pkg::ACT_CLEAR:    op_dec.is_clear = 1'b1;
    endcase
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !q_full) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_dec;
    end
  end

endmodule

// ----- design/ldsd_back.sv -----
// Back end: associative location table, dead store counter and result forming.
// A two-step sequencer first matches the key, then updates the table.
// Depends on ldsd_pkg for the event and result formats and the state type.
module ldsd_back #(
  parameter int TABLE_ENTRIES = ldsd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ldsd_pkg::op_t  q_data,
  output logic           q_pop,
  input  logic           res_full,
  output logic           res_push,
  output ldsd_pkg::res_t res_data
);

  localparam int N = TABLE_ENTRIES;

  ldsd_pkg::bk_state_t state_r, state_nxt;

  // Table entries; only the valid bits are reset.
  logic [N-1:0]                      valid_r, valid_nxt;
  logic [ldsd_pkg::BASE_W-1:0]       base_r [N];
  logic [ldsd_pkg::OFFS_W-1:0]       offs_r [N];
  logic [ldsd_pkg::TYPE_W-1:0]       type_r [N];
  logic [ldsd_pkg::TAG_W-1:0]        tag_r  [N];
  logic [ldsd_pkg::CNT_W-1:0]        count_r, count_nxt;

  // Event under work and what the lookup found.
  ldsd_pkg::op_t                     cur_r;
  logic [N-1:0]                      hit_vec_r;
  logic [ldsd_pkg::TYPE_W-1:0]       hit_type_r;
  logic [ldsd_pkg::TAG_W-1:0]        hit_tag_r;

  logic [N-1:0]                      match;
  logic [ldsd_pkg::TYPE_W-1:0]       match_type;
  logic [ldsd_pkg::TAG_W-1:0]        match_tag;
  logic                              take;
  logic                              upd;

  logic [N-1:0]                      free_vec;
  logic [N-1:0]                      first_free;
  logic [N-1:0]                      wr_vec;
  logic                              hit_any;
  logic                              tbl_full;
  logic                              same_type;
  logic                              dead;

  // Key match against every entry in parallel; at most one entry hits.
  always_comb begin
    match_type = '0;
    match_tag  = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (base_r[i] == q_data.base_id) &&
                 (offs_r[i] == q_data.loc_offset);
      if (match[i]) begin
        match_type = match_type | type_r[i];
        match_tag  = match_tag | tag_r[i];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ldsd_pkg::BK_LOOKUP: begin
        if (!q_empty && !res_full) begin
          state_nxt = ldsd_pkg::BK_UPDATE;
        end
      end
      ldsd_pkg::BK_UPDATE: state_nxt = ldsd_pkg::BK_LOOKUP;
    endcase
  end

  // State outputs.
  always_comb begin
    take = 1'b0;
    upd  = 1'b0;
    unique case (state_r)
      ldsd_pkg::BK_LOOKUP: take = !q_empty && !res_full;
      ldsd_pkg::BK_UPDATE: upd  = 1'b1;
    endcase
  end

  assign q_pop    = take;
  assign res_push = upd;

  // Update step: lowest free entry is the lowest set bit of the free vector.
  always_comb begin
    free_vec   = ~valid_r;
    first_free = free_vec & (~free_vec + 1'b1);
    hit_any    = |hit_vec_r;
    tbl_full   = &valid_r;
    same_type  = (hit_type_r == cur_r.type_id);
    dead       = cur_r.is_store && hit_any && same_type;
    wr_vec     = '0;
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    if (upd) begin
      if (cur_r.is_store) begin
        if (hit_any) begin
          wr_vec = hit_vec_r;
        end else if (!tbl_full) begin
          wr_vec    = first_free;
          valid_nxt = valid_r | first_free;
        end
      end else if (cur_r.is_erase) begin
        valid_nxt = valid_r & ~hit_vec_r;
      end else if (cur_r.is_clear) begin
        valid_nxt = '0;
      end
      if (dead && (count_r != '1)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_comb begin
    res_data            = '0;
    res_data.dead_found = dead;
    res_data.dead_tag   = dead ? hit_tag_r : '0;
    res_data.table_full = cur_r.is_store && !hit_any && tbl_full;
    res_data.dead_total = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldsd_pkg::BK_LOOKUP;
      valid_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r      <= q_data;
      hit_vec_r  <= match;
      hit_type_r <= match_type;
      hit_tag_r  <= match_tag;
    end
  end

  // A hit rewrites the key with the same value, so one write vector serves both.
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (wr_vec[i]) begin
        base_r[i] <= cur_r.base_id;
        offs_r[i] <= cur_r.loc_offset;
        type_r[i] <= cur_r.type_id;
        tag_r[i]  <= cur_r.store_tag;
      end
    end
  end

endmodule

// ----- design/local_dead_store_detector_top.sv -----
// Top level of the local dead store detector.
// Instantiates ldsd_front, two ldsd_fifo queues and ldsd_back; uses ldsd_pkg.
//
//   channel   | direction | handshake              | fields
//   ----------+-----------+------------------------+--------------------------------------
//   in_       | input     | in_push / in_full      | action, base_id, loc_offset,
//             |           |                        | type_id, store_tag
//   out_      | output    | out_pop / out_empty    | dead_found, dead_tag, table_full,
//             |           |                        | dead_total
//
// The back end takes a word in two steps: it matches the key against all table
// entries, then updates the entry and the counter and writes the result word;
// it takes no new word until the update step is done. Reset is synchronous
// and empties the table and the queues. Stalls on the result side back up
// through the queues to in_full; the front keeps taking words while the
// queues have room.
//
// Every input word gives exactly one result word, in order. The front decodes
// the action and registers the word; a short queue decouples it from the back
// end. The back end holds the associative table of tracked locations. A simple
// store that hits an entry of the same type reports the old tag as dead and
// bumps a saturating count; a store that misses claims the lowest free entry,
// or is flagged as untracked when none is free. Loads and volatile stores drop
// their entry, and a clear drops all of them. The back end only starts a word
// when the result queue has room, so its result never needs to wait.
module local_dead_store_detector_top #(
  parameter int TABLE_ENTRIES = ldsd_pkg::TABLE_ENTRIES_DEF,
  parameter int QUEUE_DEPTH   = ldsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_base_id,
  input  logic signed [31:0] in_loc_offset,
  input  logic [7:0]         in_type_id,
  input  logic [15:0]        in_store_tag,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_dead_found,
  output logic [15:0]        out_dead_tag,
  output logic               out_table_full,
  output logic [15:0]        out_dead_total
);

  localparam int OP_W  = $bits(ldsd_pkg::op_t);
  localparam int RES_W = $bits(ldsd_pkg::res_t);

  // Front to queue.
  logic           fq_push;
  ldsd_pkg::op_t  fq_data;
  logic           fq_full;
  // Queue to back.
  logic           bq_empty;
  logic           bq_pop;
  logic [OP_W-1:0] bq_bits;
  // Back to result queue.
  logic           rq_push;
  ldsd_pkg::res_t rq_data;
  logic           rq_full;
  logic [RES_W-1:0] rq_bits;
  ldsd_pkg::res_t out_word;

  ldsd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_base_id     (in_base_id),
    .in_loc_offset  (in_loc_offset),
    .in_type_id     (in_type_id),
    .in_store_tag   (in_store_tag),
    .q_push         (fq_push),
    .q_data         (fq_data),
    .q_full         (fq_full)
  );

  ldsd_fifo #(
    .W     (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_data),
    .full    (fq_full),
    .pop     (bq_pop),
    .rd_data (bq_bits),
    .empty   (bq_empty)
  );

  ldsd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (bq_empty),
    .q_data   (ldsd_pkg::op_t'(bq_bits)),
    .q_pop    (bq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res_data (rq_data)
  );

  ldsd_fifo #(
    .W     (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .wr_data (rq_data),
    .full    (rq_full),
    .pop     (out_pop),
    .rd_data (rq_bits),
    .empty   (out_empty)
  );

  // The oldest result word sits on the out_ ports while the queue is not empty.
  assign out_word       = ldsd_pkg::res_t'(rq_bits);
  assign out_dead_found = out_word.dead_found;
  assign out_dead_tag   = out_word.dead_tag;
  assign out_table_full = out_word.table_full;
  assign out_dead_total = out_word.dead_total;

endmodule
